[src/pspg_pkg.sv]
// Shared types and constants for the program association section generator.
// No dependencies; every other file of the block imports this package.
package pspg_pkg;

   // Fixed payload geometry.
   localparam int PAYLOAD_BYTES = 184;
   localparam int WORD_COUNT    = PAYLOAD_BYTES / 4;

   // Field widths.
   localparam int INDEX_W   = 5;
   localparam int PROGNUM_W = 16;
   localparam int PID_W     = 13;
   localparam int ENTRY_W   = PROGNUM_W + PID_W;
   localparam int COUNT_W   = 6;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   // Request function codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_GEN   = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_STREAM_ID     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_NEXT  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_COUNT = 8'd3;

   // MPEG-2 CRC-32 parameters.
   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // One queued request.
   typedef struct packed {
      logic                 func;
      logic [INDEX_W-1:0]   entry_index;
      logic [PROGNUM_W-1:0] prog_num;
      logic [PID_W-1:0]     map_pid;
   } cmd_type;

   // Section header settings as seen by the back end.
   typedef struct packed {
      logic [15:0]        stream_id;
      logic [4:0]         version;
      logic               current_next;
      logic [COUNT_W-1:0] program_n;
   } cfg_type;

   // Advance the CRC by one byte, most significant bit first.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h000000};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[src/pspg_cmd_fifo.sv]
// Two-entry request queue between the front end and the back end.
// Depends on pspg_pkg for the request type.
module pspg_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pspg_pkg::cmd_type push_data,
   output logic              full,
   output logic              pop_valid,
   output pspg_pkg::cmd_type pop_data,
   input  logic              pop
);
   import pspg_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'(DEPTH));
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/pspg_front.sv]
// Front end: configuration registers and request acceptance.
// Depends on pspg_pkg; feeds pspg_cmd_fifo and hands settings to pspg_back.
module pspg_front #(
   parameter int MAX_PROGRAMS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_func,
   input  logic [pspg_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [pspg_pkg::PROGNUM_W-1:0]     req_program_number,
   input  logic [pspg_pkg::PID_W-1:0]         req_map_pid,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pspg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pspg_pkg::CSR_DAT_W-1:0]     csr_wdata,
   input  logic                               fifo_full,
   output logic                               fifo_push,
   output pspg_pkg::cmd_type                  fifo_data,
   output pspg_pkg::cfg_type                  cfg
);
   import pspg_pkg::*;

   logic [15:0]        stream_id_ff;
   logic [4:0]         version_ff;
   logic               current_next_ff;
   logic [COUNT_W-1:0] program_count_ff;
   logic               in_range;

   assign csr_ready = 1'b1;
   assign busy      = fifo_full;

   // Writes to slots beyond the table are dropped here; generate requests always pass.
   assign in_range  = (int'(req_entry_index) < MAX_PROGRAMS);
   assign fifo_push = start && !busy && (req_func == FUNC_GEN || in_range);
   assign fifo_data = '{func:        req_func,
                        entry_index: req_entry_index,
                        prog_num:    req_program_number,
                        map_pid:     req_map_pid};

   // Program count saturates at the table depth.
   always_comb begin
      cfg.stream_id    = stream_id_ff;
      cfg.version      = version_ff;
      cfg.current_next = current_next_ff;
      cfg.program_n    = (int'(program_count_ff) > MAX_PROGRAMS) ?
                         COUNT_W'(MAX_PROGRAMS) : program_count_ff;
   end

   // Register file; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_id_ff     <= 16'h0000;
         version_ff       <= 5'd0;
         current_next_ff  <= 1'b1;
         program_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STREAM_ID:     stream_id_ff     <= csr_wdata;
            CSR_VERSION:       version_ff       <= csr_wdata[4:0];
            CSR_CURRENT_NEXT:  current_next_ff  <= csr_wdata[0];
            CSR_PROGRAM_COUNT: program_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

[src/pspg_back.sv]
// Back end: entry table, byte-serial CRC pass and word emission.
// Depends on pspg_pkg; takes requests from pspg_cmd_fifo.
module pspg_back #(
   parameter int MAX_PROGRAMS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  pspg_pkg::cfg_type cfg,
   input  logic              cmd_valid,
   input  pspg_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output logic [31:0]       rsp_payload_word,
   output logic [5:0]        rsp_word_index,
   output logic              rsp_last_word
);
   import pspg_pkg::*;

   localparam int AW = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_CRC, ST_EMIT} state_type;

   logic [ENTRY_W-1:0] table_mem [MAX_PROGRAMS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;

   state_type   state_ff, state_in;
   logic [5:0]  chunk_ff, chunk_in;
   logic [1:0]  lane_ff, lane_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] crc_ff, crc_in;
   logic [5:0]  word_ff, word_in;
   logic [7:0]  prev_lo_ff, prev_lo_in;
   logic        valid_ff, valid_in;
   logic [31:0] payload_ff, payload_in;
   logic [5:0]  index_ff, index_in;
   logic        last_ff, last_in;

   logic [11:0] sec_len;
   logic [31:0] hdr_a, hdr_b, entry_word, out_word;
   logic [5:0]  last_chunk;
   logic [6:0]  word_w, n_w;

   assign cmd_pop          = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid        = valid_ff;
   assign rsp_payload_word = payload_ff;
   assign rsp_word_index   = index_ff;
   assign rsp_last_word    = last_ff;

   // Section fields: header chunks for the CRC pass start at byte 1.
   assign sec_len    = 12'd9 + {4'b0000, cfg.program_n, 2'b00};
   assign hdr_a      = {8'h00, 4'hB, sec_len[11:8], sec_len[7:0], cfg.stream_id[15:8]};
   assign hdr_b      = {cfg.stream_id[7:0], 2'b11, cfg.version, cfg.current_next, 16'h0000};
   assign entry_word = {rd_data_ff[ENTRY_W-1:PID_W], 3'b111, rd_data_ff[PID_W-1:0]};
   assign last_chunk = cfg.program_n + 6'd1;
   assign word_w     = {1'b0, word_ff};
   assign n_w        = {1'b0, cfg.program_n};

   // Payload word at emission position; entries sit one byte off word alignment.
   always_comb begin
      priority if (word_ff == 6'd0) begin
         out_word = {16'h0000, 4'hB, sec_len[11:8], sec_len[7:0]};
      end else if (word_ff == 6'd1) begin
         out_word = {cfg.stream_id, 2'b11, cfg.version, cfg.current_next, 8'h00};
      end else if (word_w < n_w + 7'd2) begin
         out_word = {prev_lo_ff, rd_data_ff[ENTRY_W-1:PID_W], 3'b111,
                     rd_data_ff[PID_W-1:8]};
      end else if (word_w == n_w + 7'd2) begin
         out_word = {prev_lo_ff, crc_ff[31:8]};
      end else if (word_w == n_w + 7'd3) begin
         out_word = {crc_ff[7:0], 24'hFF_FFFF};
      end else begin
         out_word = 32'hFFFF_FFFF;
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in   = state_ff;
      chunk_in   = chunk_ff;
      lane_in    = lane_ff;
      shift_in   = shift_ff;
      crc_in     = crc_ff;
      word_in    = word_ff;
      prev_lo_in = prev_lo_ff;
      rd_addr_in = rd_addr_ff;
      valid_in   = 1'b0;
      payload_in = payload_ff;
      index_in   = index_ff;
      last_in    = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd.func == FUNC_GEN) begin
               state_in   = ST_CRC;
               chunk_in   = 6'd0;
               lane_in    = 2'd0;
               shift_in   = hdr_a;
               crc_in     = CRC_INIT;
               rd_addr_in = '0;
            end
         end
         ST_CRC: begin
            // One byte per cycle; the next chunk loads after the fourth byte.
            crc_in   = crc_byte(crc_ff, shift_ff[31:24]);
            shift_in = {shift_ff[23:0], 8'h00};
            lane_in  = lane_ff + 2'd1;
            if (lane_ff == 2'd3) begin
               if (chunk_ff == last_chunk) begin
                  state_in   = ST_EMIT;
                  word_in    = 6'd0;
                  prev_lo_in = 8'h00;
               end else begin
                  chunk_in = chunk_ff + 6'd1;
                  if (chunk_ff == 6'd0) begin
                     shift_in = hdr_b;
                  end else begin
                     shift_in   = entry_word;
                     rd_addr_in = rd_addr_ff + AW'(1);
                  end
               end
            end
         end
         ST_EMIT: begin
            // The read address runs two words ahead of the entry it serves.
            valid_in   = 1'b1;
            payload_in = out_word;
            index_in   = word_ff;
            last_in    = (word_ff == 6'(WORD_COUNT - 1));
            rd_addr_in = AW'(word_ff);
            word_in    = word_ff + 6'd1;
            if (word_ff >= 6'd2 && word_w < n_w + 7'd2) begin
               prev_lo_in = rd_data_ff[7:0];
            end
            if (word_ff == 6'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      chunk_ff   <= chunk_in;
      lane_ff    <= lane_in;
      shift_ff   <= shift_in;
      crc_ff     <= crc_in;
      word_ff    <= word_in;
      prev_lo_ff <= prev_lo_in;
      rd_addr_ff <= rd_addr_in;
      payload_ff <= payload_in;
      index_ff   <= index_in;
      last_ff    <= last_in;
   end

   // Entry table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd_pop && cmd.func == FUNC_WRITE) begin
         table_mem[AW'(cmd.entry_index)] <= {cmd.prog_num, cmd.map_pid};
      end
      rd_data_ff <= table_mem[rd_addr_ff];
   end

endmodule

[src/pat_section_packet_generator.sv]
// Top level of the program association section packet generator.
// Depends on pspg_pkg, pspg_front, pspg_cmd_fifo and pspg_back.
//
//   Channel   Handshake            Carries
//   request   start / busy         req_func, req_entry_index, req_program_number, req_map_pid
//   response  rsp_valid (strobe)   rsp_payload_word, rsp_word_index, rsp_last_word
//   config    csr_valid/csr_ready  csr_index, csr_wdata
//
// The back end takes a write request from the queue and stores it in the entry table.
// A generate request holds the back end, which takes no other request until it is done:
// it takes the request from the queue, runs the CRC over the section one byte per cycle,
// and emits the words back to back through its output registers.
// The CRC unit and the single table read port set the pace of a generate request.
// Reset clears the queue, sequencer and configuration registers; the entry table is not cleared.
// The receiver cannot stall; busy rises only when the two-deep request queue is full.
module pat_section_packet_generator #(
   parameter int MAX_PROGRAMS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_func,
   input  logic [pspg_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [pspg_pkg::PROGNUM_W-1:0] req_program_number,
   input  logic [pspg_pkg::PID_W-1:0]     req_map_pid,
   output logic                           rsp_valid,
   output logic [31:0]                    rsp_payload_word,
   output logic [5:0]                     rsp_word_index,
   output logic                           rsp_last_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pspg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pspg_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import pspg_pkg::*;

   logic    fifo_full;
   logic    fifo_push;
   cmd_type fifo_in;
   logic    fifo_valid;
   cmd_type fifo_out;
   logic    fifo_pop;
   cfg_type cfg;

   // Request acceptance and configuration registers.
   pspg_front #(.MAX_PROGRAMS(MAX_PROGRAMS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_entry_index    (req_entry_index),
      .req_program_number (req_program_number),
      .req_map_pid        (req_map_pid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fifo_full          (fifo_full),
      .fifo_push          (fifo_push),
      .fifo_data          (fifo_in),
      .cfg                (cfg)
   );

   // Request queue between the two halves.
   pspg_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_in),
      .full      (fifo_full),
      .pop_valid (fifo_valid),
      .pop_data  (fifo_out),
      .pop       (fifo_pop)
   );

   // Table, CRC and payload emission.
   pspg_back #(.MAX_PROGRAMS(MAX_PROGRAMS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd_valid        (fifo_valid),
      .cmd              (fifo_out),
      .cmd_pop          (fifo_pop),
      .rsp_valid        (rsp_valid),
      .rsp_payload_word (rsp_payload_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word)
   );

endmodule
